[rtl/assert_macros.svh]
// Assertion helpers; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, inactive during reset.
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, inactive during reset.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/dsi_pkg.sv]
`default_nettype none

package dsi_pkg;

    localparam int CH_W    = 8;
    localparam int ACC_W   = 63;
    localparam int VAL_W   = 64;
    localparam int SCALE_W = 5;
    localparam int DIG_W   = 4;

    localparam logic [CH_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CH_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CHAR_NINE  = 8'h39;

    // Largest accumulator that still takes one more digit (9) without overflow.
    localparam logic [ACC_W-1:0] ACC_LIMIT = 63'd922337203685477579;
    // Largest accumulator that still takes one more times-ten pad step.
    localparam logic [ACC_W-1:0] PAD_LIMIT = 63'd922337203685477580;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 5'd8;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CHAR = 4'b0010,
        S_PAD  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    typedef struct packed {
        logic [ACC_W-1:0] operand;
        logic [DIG_W-1:0] digit;
        logic             pad;
    } unit_req_t;

    typedef struct packed {
        logic [ACC_W-1:0] product;
        logic             over;
    } unit_rsp_t;

    typedef struct packed {
        logic [VAL_W-1:0] scaled_value;
        logic             ok;
    } result_t;

endpackage

`default_nettype wire

[rtl/dsi_if.sv]
`default_nettype none

interface dsi_char_if import dsi_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;
    logic            has_char;
    logic            end_of_string;

    modport source (output valid, ch, has_char, end_of_string, input ready);
    modport sink   (input valid, ch, has_char, end_of_string, output ready);
endinterface

interface dsi_result_if import dsi_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] scaled_value;
    logic                    ok;

    modport source (output valid, scaled_value, ok, input ready);
    modport sink   (input valid, scaled_value, ok, output ready);
endinterface

`default_nettype wire

[rtl/decimal_string_to_scaled_int.sv]
// Decimal string to scaled signed integer converter.
// char_in carries one ASCII character per transaction (ch, has_char) with
// end_of_string marking the last one; has_char = 0 sends a bare end marker.
// result_out carries one transaction per string: scaled_value (number times
// ten to frac_scale, two's complement, zero on failure) and ok.
// frac_scale is written through cfg_wr_en / cfg_wr_data; the user must write it
// only while the block is idle, which the block itself does not enforce.
// Each character is accepted, then updated once through the shared
// times-ten-plus-digit unit; ready is low during the update.
// The end transaction follows its update with (frac_scale - fraction digits
// kept) pad steps through the same unit (fewer once a failure is known), then a
// finishing step and the load of the output register once the slot is free.
// A finished result waits in the output register; the next string's
// characters are still taken while it waits, and only the next result holds
// until the receiver takes it.
// Reset clears the string state, empties the output register and sets
// frac_scale to 8.
`default_nettype none
`include "assert_macros.svh"

module decimal_string_to_scaled_int import dsi_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [SCALE_W-1:0]  cfg_wr_data,
    dsi_char_if.sink            char_in,
    dsi_result_if.source        result_out
);

    logic [SCALE_W-1:0] frac_scale_reg;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg;
    unit_req_t          unit_req;
    unit_rsp_t          unit_rsp;
    result_t            res;
    logic               res_load;
    logic               res_free;

    // Output slot is free when empty or being drained this cycle.
    assign res_free = !out_valid_reg || result_out.ready;

    dsi_mul10 u_mul10 (
        .req (unit_req),
        .rsp (unit_rsp)
    );

    dsi_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .frac_scale    (frac_scale_reg),
        .in_valid      (char_in.valid),
        .in_ready      (char_in.ready),
        .ch            (char_in.ch),
        .has_char      (char_in.has_char),
        .end_of_string (char_in.end_of_string),
        .unit_req      (unit_req),
        .unit_rsp      (unit_rsp),
        .res_free      (res_free),
        .res_load      (res_load),
        .res           (res)
    );

    // Load on a new result, drop once the receiver takes it.
    always_comb
    begin
        priority if (res_load)
            out_valid_next = 1'b1;
        else if (result_out.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_scale_reg <= SCALE_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                frac_scale_reg <= cfg_wr_data;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result payload until the slot is reloaded.
    always_ff @(posedge clk)
    begin
        if (res_load)
            out_reg <= res;
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.scaled_value = out_reg.scaled_value;
    assign result_out.ok           = out_reg.ok;

    // A failed string reports zero.
    `ASSERT_SAME(a_fail_zero, out_valid_reg && !out_reg.ok, out_reg.scaled_value == '0)
    // A good result never reaches the most negative code.
    `ASSERT_SAME(a_ok_range, out_valid_reg && out_reg.ok,
        !(out_reg.scaled_value[VAL_W-1] && (out_reg.scaled_value[VAL_W-2:0] == '0)))
    // Every accepted character is followed by an update cycle.
    `ASSERT_NEXT(a_busy_after_accept, char_in.valid && char_in.ready, !char_in.ready)
    // A new result is only loaded into a free slot.
    `ASSERT_SAME(a_load_free, res_load, !out_valid_reg || result_out.ready)

endmodule

`default_nettype wire

[rtl/dsi_mul10.sv]
`default_nettype none

// Shared times-ten-plus-digit unit with overflow guard.
module dsi_mul10 import dsi_pkg::*; (
    input  unit_req_t req,
    output unit_rsp_t rsp
);

    logic [ACC_W-1:0] limit;

    always_comb
    begin
        limit       = req.pad ? PAD_LIMIT : ACC_LIMIT;
        rsp.over    = req.operand > limit;
        rsp.product = {req.operand[ACC_W-4:0], 3'b000}
                    + {req.operand[ACC_W-2:0], 1'b0}
                    + ACC_W'(req.digit);
    end

endmodule

`default_nettype wire

[rtl/dsi_ctrl.sv]
`default_nettype none

// Sequencer and string state: one character per pass, then pad steps at the end.
module dsi_ctrl import dsi_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [SCALE_W-1:0] frac_scale,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [CH_W-1:0]    ch,
    input  logic               has_char,
    input  logic               end_of_string,
    output unit_req_t          unit_req,
    input  unit_rsp_t          unit_rsp,
    input  logic               res_free,
    output logic               res_load,
    output result_t            res
);

    state_t             state_reg, state_next;
    logic [CH_W-1:0]    ch_reg, ch_next;
    logic               has_reg, has_next;
    logic               last_reg, last_next;
    logic [ACC_W-1:0]   accum_reg, accum_next;
    logic [SCALE_W-1:0] frac_count_reg, frac_count_next;
    logic               seen_point_reg, seen_point_next;
    logic               seen_digit_reg, seen_digit_next;
    logic               negative_reg, negative_next;
    logic               failed_reg, failed_next;
    logic               at_start_reg, at_start_next;
    logic               is_digit;
    logic               good;
    logic [VAL_W-1:0]   mag;

    assign is_digit = (ch_reg >= CHAR_ZERO) && (ch_reg <= CHAR_NINE);
    assign good     = !failed_reg && seen_digit_reg;
    assign mag      = {1'b0, accum_reg};
    assign in_ready = (state_reg == S_IDLE);
    assign res_load = (state_reg == S_DONE) && res_free;

    assign unit_req.operand = accum_reg;
    assign unit_req.digit   = (state_reg == S_PAD) ? '0 : ch_reg[DIG_W-1:0];
    assign unit_req.pad     = (state_reg == S_PAD);

    assign res.ok           = good;
    assign res.scaled_value = !good ? '0 : (negative_reg ? VAL_W'(0) - mag : mag);

    always_comb
    begin
        state_next      = state_reg;
        ch_next         = ch_reg;
        has_next        = has_reg;
        last_next       = last_reg;
        accum_next      = accum_reg;
        frac_count_next = frac_count_reg;
        seen_point_next = seen_point_reg;
        seen_digit_next = seen_digit_reg;
        negative_next   = negative_reg;
        failed_next     = failed_reg;
        at_start_next   = at_start_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ch_next    = ch;
                    has_next   = has_char;
                    last_next  = end_of_string;
                    state_next = S_CHAR;
                end
            end
            S_CHAR:
            begin
                if (has_reg)
                begin
                    at_start_next = 1'b0;
                    if (failed_reg)
                    begin
                        // sticky failure: drop the character
                    end
                    else if (ch_reg == CHAR_MINUS && at_start_reg)
                        negative_next = 1'b1;
                    else if (ch_reg == CHAR_DOT)
                    begin
                        if (seen_point_reg)
                            failed_next = 1'b1;
                        seen_point_next = 1'b1;
                    end
                    else if (!is_digit)
                        failed_next = 1'b1;
                    else
                    begin
                        seen_digit_next = 1'b1;
                        if (seen_point_reg && frac_count_reg >= frac_scale)
                        begin
                            // digits past the scale must be zero
                            if (ch_reg != CHAR_ZERO)
                                failed_next = 1'b1;
                        end
                        else if (unit_rsp.over)
                            failed_next = 1'b1;
                        else
                        begin
                            accum_next = unit_rsp.product;
                            if (seen_point_reg)
                                frac_count_next = frac_count_reg + SCALE_W'(1);
                        end
                    end
                end
                state_next = last_reg ? S_PAD : S_IDLE;
            end
            S_PAD:
            begin
                if (good && frac_count_reg < frac_scale)
                begin
                    if (unit_rsp.over)
                        failed_next = 1'b1;
                    else
                    begin
                        accum_next      = unit_rsp.product;
                        frac_count_next = frac_count_reg + SCALE_W'(1);
                    end
                end
                else
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_free)
                begin
                    accum_next      = '0;
                    frac_count_next = '0;
                    seen_point_next = 1'b0;
                    seen_digit_next = 1'b0;
                    negative_next   = 1'b0;
                    failed_next     = 1'b0;
                    at_start_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            accum_reg      <= '0;
            frac_count_reg <= '0;
            seen_point_reg <= 1'b0;
            seen_digit_reg <= 1'b0;
            negative_reg   <= 1'b0;
            failed_reg     <= 1'b0;
            at_start_reg   <= 1'b1;
        end
        else
        begin
            state_reg      <= state_next;
            accum_reg      <= accum_next;
            frac_count_reg <= frac_count_next;
            seen_point_reg <= seen_point_next;
            seen_digit_reg <= seen_digit_next;
            negative_reg   <= negative_next;
            failed_reg     <= failed_next;
            at_start_reg   <= at_start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg   <= ch_next;
        has_reg  <= has_next;
        last_reg <= last_next;
    end

endmodule

`default_nettype wire
